// File: design/atw_pkg.sv
// Shared types and constants for the text terminal writer.
package atw_pkg;

    localparam logic [7:0] ATTR_RESET  = 8'h07;
    localparam logic [7:0] ESC_CHAR    = 8'h1B;
    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [8:0] BACKSPACE   = 9'h100;
    localparam logic [8:0] NEWLINE     = 9'h00A;
    localparam logic [8:0] OPEN_SQUARE = 9'h05B;
    localparam logic [8:0] SEMICOLON   = 9'h03B;
    localparam logic [8:0] LETTER_M    = 9'h06D;
    localparam logic [8:0] DIGIT_0     = 9'h030;
    localparam logic [8:0] DIGIT_9     = 9'h039;
    localparam logic [7:0] NIBBLE_HI   = 8'hF0;
    localparam logic [7:0] NIBBLE_LO   = 8'h0F;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_SEQUENCE
    } t_mode;

    typedef enum logic [2:0] {
        K_SWALLOW,
        K_ESC_OTHER,
        K_NEWLINE,
        K_BACKSPACE,
        K_PRINT
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_CLR,
        OP_CAPTURE,
        OP_READ_LATCH,
        OP_PARSE,
        OP_NEWLINE,
        OP_BACK,
        OP_PUT_CHAR,
        OP_PUT_ESC,
        OP_SCROLL_START,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_SCROLL_POS,
        OP_ROW_CLR,
        OP_BLANK,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RWAIT,
        ST_NL,
        ST_BS,
        ST_PUTC,
        ST_PUTE,
        ST_CHECK,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_SCROLL_POS,
        ST_ROW_CLR,
        ST_BLANK,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_kind kind;
        logic  term_ok;
        logic  is_read;
        logic  pos_over;
        logic  copy_done;
        logic  row_done;
        logic  init_done;
        logic  out_ready;
    } t_stat;

endpackage

// File: design/atw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module atw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/atw_dp.sv
// Datapath: per-terminal parser state, cursor arithmetic, screen memory and result register.
module atw_dp
    import atw_pkg::*;
#(
    parameter int TERMINALS = 6,
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    output t_stat       o_stat,
    input  logic        i_cfg_valid,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_action,
    input  logic [2:0]  i_terminal,
    input  logic [8:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_cell_value,
    output logic [10:0] o_cursor_pos,
    output logic        o_error
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int TOTAL = TERMINALS * CELLS;
    localparam int PW    = $clog2(CELLS + COLUMNS + 1);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(TOTAL);
    localparam int TW    = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    logic [PW-1:0] r_cursor [TERMINALS];
    logic [CW-1:0] r_colreg [TERMINALS];
    t_mode         r_mode   [TERMINALS];
    logic [7:0]    r_attr   [TERMINALS];
    logic [7:0]    r_code   [TERMINALS];

    logic [7:0]    r_def;
    logic          r_action;
    logic [2:0]    r_term;
    logic [8:0]    r_char;
    logic [10:0]   r_idx;
    logic [PW-1:0] r_pos;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_ctr;
    logic [15:0]   r_value;
    logic          r_err;
    logic          r_out_valid;
    logic [15:0]   r_out_value;
    logic [10:0]   r_out_cursor;
    logic          r_out_err;

    logic [TW-1:0] w_ti;
    logic [TW-1:0] w_ti_in;
    logic          w_term_ok;
    logic          w_term_in_ok;
    t_mode         w_mode;
    t_kind         w_kind;
    logic [7:0]    w_attr;
    logic [7:0]    w_code;
    logic [AW-1:0] w_base;
    logic          w_pos_over;
    logic          w_idx_ok;
    logic [PW-1:0] w_pos_inc;
    logic [CW-1:0] w_col_inc;
    logic [11:0]   w_code10;
    logic          w_digit;
    logic [7:0]    w_applied;
    logic          w_bad_code;
    logic [3:0]    w_n_lo;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [15:0]   w_wdata;
    logic [AW-1:0] w_raddr;
    logic [15:0]   w_rdata;
    logic          w_out_ready;

    assign w_ti         = r_term[TW-1:0];
    assign w_ti_in      = i_terminal[TW-1:0];
    assign w_term_ok    = 32'(r_term) < TERMINALS;
    assign w_term_in_ok = 32'(i_terminal) < TERMINALS;
    assign w_mode       = r_mode[w_ti];
    assign w_attr       = r_attr[w_ti];
    assign w_code       = r_code[w_ti];
    assign w_base       = AW'(r_term) * AW'(CELLS);
    assign w_pos_over   = 32'(r_pos) >= CELLS;
    assign w_idx_ok     = 32'(r_idx) < CELLS;
    assign w_pos_inc    = r_pos + PW'(1);
    assign w_col_inc    = (32'(r_col) == COLUMNS - 1) ? '0 : r_col + CW'(1);
    assign w_digit      = (r_char >= DIGIT_0) && (r_char <= DIGIT_9);
    assign w_code10     = 12'(w_code) * 12'd10 + 12'(r_char[3:0]);
    assign w_out_ready  = !r_out_valid || !i_out_stall;

    always_comb begin
        priority if (w_mode == MODE_NORMAL && r_char == 9'(ESC_CHAR)) begin
            w_kind = K_SWALLOW;
        end else if (w_mode == MODE_ESCAPE && r_char == OPEN_SQUARE) begin
            w_kind = K_SWALLOW;
        end else if (w_mode == MODE_ESCAPE) begin
            w_kind = K_ESC_OTHER;
        end else if (w_mode == MODE_SEQUENCE) begin
            w_kind = K_SWALLOW;
        end else if (r_char == NEWLINE) begin
            w_kind = K_NEWLINE;
        end else if (r_char == BACKSPACE) begin
            w_kind = K_BACKSPACE;
        end else begin
            w_kind = K_PRINT;
        end
    end

    // Colour code decode; the low nibble of n minus 30 or 40 equals n minus 30 or 40 here.
    always_comb begin
        w_bad_code = 1'b0;
        w_applied  = w_attr;
        w_n_lo     = 4'(w_code - ((w_code >= 8'd40) ? 8'd40 : 8'd30));
        priority if (w_code == 8'd0) begin
            w_applied = r_def;
        end else if (w_code >= 8'd30 && w_code <= 8'd37) begin
            w_applied = {w_attr[7:4], w_n_lo};
        end else if (w_code == 8'd39) begin
            w_applied = (w_attr & NIBBLE_HI) | (r_def & NIBBLE_LO);
        end else if (w_code >= 8'd40 && w_code <= 8'd47) begin
            w_applied = {w_n_lo, w_attr[3:0]};
        end else if (w_code == 8'd49) begin
            w_applied = (w_attr & NIBBLE_LO) | (r_def & NIBBLE_HI);
        end else begin
            w_bad_code = 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_base + AW'(r_pos);
        w_wdata = '0;
        unique case (i_op)
            OP_INIT_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_ctr;
            end
            OP_PUT_CHAR: begin
                w_we    = !w_pos_over;
                w_wdata = {w_attr, r_char[7:0]};
            end
            OP_PUT_ESC: begin
                w_we    = !w_pos_over;
                w_wdata = {w_attr, ESC_CHAR};
            end
            OP_COPY_WR: begin
                w_we    = 1'b1;
                w_waddr = w_base + r_ctr;
                w_wdata = w_rdata;
            end
            OP_ROW_CLR: begin
                w_we    = 1'b1;
                w_waddr = w_base + r_ctr;
            end
            OP_BLANK: begin
                w_we    = !w_pos_over;
                w_wdata = {r_def, BLANK_CHAR};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_raddr = (i_op == OP_COPY_RD) ? (w_base + r_ctr + AW'(COLUMNS))
                                          : (w_base + AW'(r_idx));

    atw_ram #(
        .WIDTH (16),
        .DEPTH (TOTAL)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def       <= ATTR_RESET;
            r_ctr       <= '0;
            r_pos       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < TERMINALS; t++) begin
                r_cursor[t] <= '0;
                r_colreg[t] <= '0;
                r_mode[t]   <= MODE_NORMAL;
                r_attr[t]   <= ATTR_RESET;
                r_code[t]   <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_def <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_op)
                OP_INIT_CLR: begin
                    r_ctr <= r_ctr + AW'(1);
                end
                OP_CAPTURE: begin
                    r_action <= i_action;
                    r_term   <= i_terminal;
                    r_char   <= i_char_code;
                    r_idx    <= i_cell_index;
                    r_value  <= '0;
                    r_err    <= 1'b0;
                    r_pos    <= w_term_in_ok ? r_cursor[w_ti_in] : '0;
                    r_col    <= w_term_in_ok ? r_colreg[w_ti_in] : '0;
                end
                OP_READ_LATCH: begin
                    r_value <= w_idx_ok ? w_rdata : '0;
                end
                OP_PARSE: begin
                    unique case (w_mode)
                        MODE_NORMAL: begin
                            if (r_char == 9'(ESC_CHAR)) begin
                                r_mode[w_ti] <= MODE_ESCAPE;
                            end
                        end
                        MODE_ESCAPE: begin
                            if (r_char == OPEN_SQUARE) begin
                                r_mode[w_ti] <= MODE_SEQUENCE;
                                r_code[w_ti] <= '0;
                            end else begin
                                r_mode[w_ti] <= MODE_NORMAL;
                            end
                        end
                        MODE_SEQUENCE: begin
                            priority if (w_digit) begin
                                r_code[w_ti] <= (w_code10 > 12'd255) ? 8'd255 : w_code10[7:0];
                            end else if (r_char == SEMICOLON || r_char == LETTER_M) begin
                                r_attr[w_ti] <= w_applied;
                                r_err        <= w_bad_code;
                                r_code[w_ti] <= '0;
                                if (r_char == LETTER_M) begin
                                    r_mode[w_ti] <= MODE_NORMAL;
                                end
                            end else begin
                                r_err        <= 1'b1;
                                r_code[w_ti] <= '0;
                                r_mode[w_ti] <= MODE_NORMAL;
                            end
                        end
                        default: begin
                            r_mode[w_ti] <= MODE_NORMAL;
                        end
                    endcase
                end
                OP_NEWLINE: begin
                    r_pos <= r_pos + PW'(COLUMNS) - PW'(r_col);
                    r_col <= '0;
                end
                OP_BACK: begin
                    if (r_pos != '0) begin
                        r_pos <= r_pos - PW'(1);
                        r_col <= (r_col == '0) ? CW'(COLUMNS - 1) : r_col - CW'(1);
                    end
                end
                OP_PUT_CHAR, OP_PUT_ESC: begin
                    r_pos <= w_pos_inc;
                    r_col <= w_col_inc;
                end
                OP_SCROLL_START: begin
                    r_ctr <= '0;
                end
                OP_COPY_WR: begin
                    r_ctr <= r_ctr + AW'(1);
                end
                OP_SCROLL_POS: begin
                    r_pos <= r_pos - PW'(COLUMNS);
                    r_ctr <= AW'(r_pos - PW'(COLUMNS));
                end
                OP_ROW_CLR: begin
                    r_ctr <= r_ctr + AW'(1);
                end
                OP_BLANK: begin
                    r_cursor[w_ti] <= r_pos;
                    r_colreg[w_ti] <= r_col;
                end
                OP_OUT: begin
                    r_out_valid  <= 1'b1;
                    r_out_value  <= r_value;
                    r_out_cursor <= w_term_ok ? 11'(r_cursor[w_ti]) : '0;
                    r_out_err    <= r_err;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.kind      = w_kind;
    assign o_stat.term_ok   = w_term_ok;
    assign o_stat.is_read   = r_action;
    assign o_stat.pos_over  = w_pos_over;
    assign o_stat.copy_done = 32'(r_ctr) == (ROWS - 1) * COLUMNS - 1;
    assign o_stat.row_done  = 32'(r_ctr) == CELLS - 1;
    assign o_stat.init_done = 32'(r_ctr) == TOTAL - 1;
    assign o_stat.out_ready = w_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_cell_value = r_out_value;
    assign o_cursor_pos = r_out_cursor;
    assign o_error      = r_out_err;

    a_blank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_BLANK) |-> !w_pos_over)
        else $error("blank cell written with the cursor past the screen");

    a_out_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT) |-> w_out_ready)
        else $error("result register loaded while a result is still held");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < COLUMNS)
        else $error("column tracker out of range");

    a_scroll_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_SCROLL_POS) |=> !w_pos_over)
        else $error("scroll left the cursor past the screen");

endmodule

// File: design/atw_ctrl.sv
// Controller: sequences each request through parse, cell writes, scrolling and the result.
module atw_ctrl
    import atw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_op   o_op
);

    t_state r_state;
    t_state n_state;
    logic   r_second;
    logic   n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        o_op     = OP_NONE;
        unique case (r_state)
            ST_INIT: begin
                o_op = OP_INIT_CLR;
                if (i_stat.init_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_CAPTURE;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                priority if (!i_stat.term_ok) begin
                    n_state = ST_OUT;
                end else if (i_stat.is_read) begin
                    n_state = ST_RWAIT;
                end else begin
                    o_op = OP_PARSE;
                    unique case (i_stat.kind)
                        K_SWALLOW:   n_state = ST_OUT;
                        K_NEWLINE:   n_state = ST_NL;
                        K_BACKSPACE: n_state = ST_BS;
                        K_PRINT:     n_state = ST_PUTC;
                        K_ESC_OTHER: begin
                            n_state  = ST_PUTE;
                            n_second = 1'b1;
                        end
                        default:     n_state = ST_OUT;
                    endcase
                end
            end
            ST_RWAIT: begin
                o_op    = OP_READ_LATCH;
                n_state = ST_OUT;
            end
            ST_NL: begin
                o_op    = OP_NEWLINE;
                n_state = ST_CHECK;
            end
            ST_BS: begin
                o_op    = OP_BACK;
                n_state = ST_CHECK;
            end
            ST_PUTC: begin
                o_op     = OP_PUT_CHAR;
                n_second = 1'b0;
                n_state  = ST_CHECK;
            end
            ST_PUTE: begin
                o_op    = OP_PUT_ESC;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (i_stat.pos_over) begin
                    o_op    = OP_SCROLL_START;
                    n_state = ST_COPY_RD;
                end else if (r_second) begin
                    n_state = ST_PUTC;
                end else begin
                    n_state = ST_BLANK;
                end
            end
            ST_COPY_RD: begin
                o_op    = OP_COPY_RD;
                n_state = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                o_op    = OP_COPY_WR;
                n_state = i_stat.copy_done ? ST_SCROLL_POS : ST_COPY_RD;
            end
            ST_SCROLL_POS: begin
                o_op    = OP_SCROLL_POS;
                n_state = ST_ROW_CLR;
            end
            ST_ROW_CLR: begin
                o_op = OP_ROW_CLR;
                if (i_stat.row_done) begin
                    n_state = r_second ? ST_PUTC : ST_BLANK;
                end
            end
            ST_BLANK: begin
                o_op    = OP_BLANK;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_ready) begin
                    o_op    = OP_OUT;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_EXEC))
        else $error("accepted request did not start execution");

    a_second_only_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_second && r_state == ST_BLANK) |-> 1'b0)
        else $error("blank cell reached with the second character still pending");

    a_out_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_OUT) |=> (r_state == ST_IDLE))
        else $error("result issued without returning to idle");

endmodule

// File: design/ansi_text_terminal_writer.sv
// Text terminal writer with several virtual screens and colour escape parsing.
// After reset the block clears all TERMINALS*ROWS*COLUMNS screen cells, one per cycle,
// and takes no request until that is done; the default attribute may be written at any
// time. A request is taken only when the sequencer is idle, and each runs through the one
// write port of the screen memory: a read latches the addressed cell, a request swallowed
// by the escape parser only updates the parser state, a newline, backspace or printable
// character moves the cursor and writes a blank cell under it, and an escape followed by
// another character writes the escape, the character and then the blank cell. A scroll
// moves each cell up one row by a read and a write, then clears from the new cursor to the
// end of the screen. The finished result waits in an output register while the next request is taken.
module ansi_text_terminal_writer
    import atw_pkg::*;
#(
    parameter int TERMINALS = 6,
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [2:0]  i_terminal,
    input  logic [8:0]  i_char_code,
    input  logic [10:0] i_cell_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_cell_value,
    output logic [10:0] o_cursor_pos,
    output logic        o_error
);

    t_op   w_op;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    atw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_op       (w_op)
    );

    atw_dp #(
        .TERMINALS (TERMINALS),
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (w_op),
        .o_stat       (w_stat),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_terminal   (i_terminal),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_value (o_cell_value),
        .o_cursor_pos (o_cursor_pos),
        .o_error      (o_error)
    );

endmodule

// File: bench/tb_ansi_text_terminal_writer.sv
// Self-checking testbench for the multi-screen ANSI colour text terminal writer.
`timescale 1ns / 100ps

module tb_ansi_text_terminal_writer;
    import atw_pkg::*;

    localparam int TERMS = 6;
    localparam int COLS  = 80;
    localparam int ROWN  = 24;
    localparam int CELLS = ROWN * COLS;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef struct {
        logic [15:0] cell_value;
        logic [10:0] cursor;
        logic        err;
    } t_term_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [2:0]  i_terminal;
    logic [8:0]  i_char_code;
    logic [10:0] i_cell_index;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_cell_value;
    logic [10:0] o_cursor_pos;
    logic        o_error;

    ansi_text_terminal_writer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_action(i_action), .i_terminal(i_terminal),
        .i_char_code(i_char_code), .i_cell_index(i_cell_index),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_cell_value(o_cell_value), .o_cursor_pos(o_cursor_pos), .o_error(o_error)
    );

    // Predicted terminal state.
    logic [15:0] screen_model [TERMS][CELLS];
    int unsigned cursor_model [TERMS];
    t_mode       mode_model   [TERMS];
    logic [7:0]  attr_model   [TERMS];
    logic [7:0]  code_model   [TERMS];
    logic [7:0]  default_attr;

    t_term_result pending_results[$];
    int  failures;
    int  requests_sent;
    int  results_checked;
    int  scrolls_seen;
    bit  quiet_phase;
    int  out_burst;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = 1'b1;
            #5 i_clk = 1'b0;
        end
    end

    initial begin
        #100_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void store_cell(int t, int unsigned p, logic [7:0] ch);
        if (p < CELLS) screen_model[t][p] = {attr_model[t], ch};
    endfunction

    function automatic int unsigned scroll_if_full(int t, int unsigned p);
        int unsigned q;
        q = p;
        if (q / COLS >= ROWN) begin
            scrolls_seen++;
            for (int i = 0; i < (ROWN - 1) * COLS; i++)
                screen_model[t][i] = screen_model[t][i + COLS];
            q = q - COLS;
            if (q < CELLS) begin
                for (int i = q; i < CELLS; i++) screen_model[t][i] = '0;
            end else begin
                q = CELLS - 1;
            end
        end
        return q;
    endfunction

    // Returns 1 when the colour code is not recognised.
    function automatic bit apply_colour(int t, logic [7:0] n);
        logic [7:0] a;
        a = attr_model[t];
        if (n == 0) a = default_attr;
        else if (n >= 30 && n <= 37) a = (a & NIBBLE_HI) | 8'(n - 30);
        else if (n == 39) a = (a & NIBBLE_HI) | (default_attr & NIBBLE_LO);
        else if (n >= 40 && n <= 47) a = (a & NIBBLE_LO) | 8'((n - 40) << 4);
        else if (n == 49) a = (a & NIBBLE_LO) | (default_attr & NIBBLE_HI);
        else return 1'b1;
        attr_model[t] = a;
        return 1'b0;
    endfunction

    function automatic t_term_result predict_terminal_step(logic act, logic [2:0] term,
                                                           logic [8:0] c, logic [10:0] idx);
        t_term_result r;
        int t;
        int unsigned p;
        bit blank;
        int unsigned n;
        r.cell_value = '0;
        r.cursor = '0;
        r.err = 1'b0;
        t = int'(term);
        blank = 1'b1;
        if (t >= TERMS) return r;
        p = cursor_model[t];
        if (act == ACT_READ) begin
            if (idx < CELLS) r.cell_value = screen_model[t][idx];
            r.cursor = 11'(p);
            return r;
        end
        if (mode_model[t] == MODE_NORMAL && c == {1'b0, ESC_CHAR}) begin
            mode_model[t] = MODE_ESCAPE;
            blank = 1'b0;
        end else if (mode_model[t] == MODE_ESCAPE && c == OPEN_SQUARE) begin
            mode_model[t] = MODE_SEQUENCE;
            code_model[t] = '0;
            blank = 1'b0;
        end else if (mode_model[t] == MODE_ESCAPE) begin
            mode_model[t] = MODE_NORMAL;
            store_cell(t, p, ESC_CHAR);
            p = scroll_if_full(t, p + 1);
            store_cell(t, p, c[7:0]);
            p++;
        end else if (mode_model[t] == MODE_SEQUENCE) begin
            blank = 1'b0;
            if (c >= DIGIT_0 && c <= DIGIT_9) begin
                n = code_model[t] * 10 + (c - DIGIT_0);
                code_model[t] = (n > 255) ? 8'd255 : n[7:0];
            end else if (c == SEMICOLON || c == LETTER_M) begin
                if (apply_colour(t, code_model[t])) r.err = 1'b1;
                code_model[t] = '0;
                if (c == LETTER_M) mode_model[t] = MODE_NORMAL;
            end else begin
                r.err = 1'b1;
                code_model[t] = '0;
                mode_model[t] = MODE_NORMAL;
            end
        end else if (c == NEWLINE) begin
            p = p + COLS - p % COLS;
        end else if (c == BACKSPACE) begin
            if (p > 0) p--;
        end else begin
            store_cell(t, p, c[7:0]);
            p++;
        end
        if (blank) begin
            p = scroll_if_full(t, p);
            if (p < CELLS) screen_model[t][p] = {default_attr, BLANK_CHAR};
            cursor_model[t] = p;
        end
        r.cursor = 11'(cursor_model[t]);
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(logic act, logic [2:0] term, logic [8:0] c, logic [10:0] idx);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_terminal   <= term;
        i_char_code  <= c;
        i_cell_index <= idx;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        pending_results.push_back(predict_terminal_step(act, term, c, idx));
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic put_char(int t, logic [8:0] c);
        send_request(ACT_PUT, t[2:0], c, 11'($urandom));
    endtask

    task automatic put_code_sequence(int t, int a, int b);
        string s;
        s = $sformatf("%0d;%0d", a, b);
        put_char(t, {1'b0, ESC_CHAR});
        put_char(t, OPEN_SQUARE);
        for (int i = 0; i < s.len(); i++) put_char(t, {1'b0, s[i]});
        put_char(t, LETTER_M);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_default_attr(logic [7:0] v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        default_attr = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (quiet_phase) begin
            i_out_stall <= 1'b0;
        end else if (out_burst > 0) begin
            out_burst--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_burst = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_term_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result cell=%h cursor=%0d error=%b",
                         $time, o_cell_value, o_cursor_pos, o_error);
                failures++;
            end else begin
                e = pending_results.pop_front();
                results_checked++;
                if (o_cell_value !== e.cell_value) begin
                    $display("%0t: cell_value expected %h actual %h",
                             $time, e.cell_value, o_cell_value);
                    failures++;
                end
                if (o_cursor_pos !== e.cursor) begin
                    $display("%0t: cursor_pos expected %0d actual %0d",
                             $time, e.cursor, o_cursor_pos);
                    failures++;
                end
                if (o_error !== e.err) begin
                    $display("%0t: error expected %b actual %b", $time, e.err, o_error);
                    failures++;
                end
            end
        end
    end

    task automatic test_printables();
        put_char(0, 9'h041);
        put_char(0, 9'h000);
        put_char(0, 9'h0FF);
        put_char(0, 9'h1C3);
        put_char(0, BACKSPACE);
        put_char(0, NEWLINE);
        send_request(ACT_READ, 3'd0, '0, 11'd0);
        send_request(ACT_READ, 3'd0, '0, 11'd2047);
        send_request(ACT_READ, 3'd7, 9'h1FF, 11'd1);
        put_char(6, 9'h041);
        put_char(2, BACKSPACE);
    endtask

    task automatic test_colour_codes();
        put_code_sequence(1, 31, 44);
        put_char(1, 9'h058);
        put_code_sequence(1, 0, 99);
        put_code_sequence(1, 39, 49);
        send_request(ACT_READ, 3'd1, '0, 11'd0);
    endtask

    task automatic test_escape_cases();
        put_char(3, {1'b0, ESC_CHAR});
        put_char(3, NEWLINE);
        put_char(3, {1'b0, ESC_CHAR});
        put_char(3, OPEN_SQUARE);
        put_char(3, 9'h07A);
        put_char(3, {1'b0, ESC_CHAR});
        put_char(3, OPEN_SQUARE);
        for (int i = 0; i < 4; i++) put_char(3, DIGIT_9);
        put_char(3, LETTER_M);
    endtask

    task automatic test_scroll();
        put_char(4, 9'h051);
        for (int i = 0; i < ROWN + 1; i++) put_char(4, NEWLINE);
        send_request(ACT_READ, 3'd4, '0, 11'd0);
    endtask

    task automatic test_random(int count);
        int k;
        int t;
        int codes [$] = '{0, 30, 37, 39, 40, 47, 49, 1, 38, 255, 48};
        quiet_phase = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) wait_drained();
            if (i > count * 4 / 5) quiet_phase = 1'b1;
            t = $urandom_range(0, 7);
            k = $urandom_range(0, 99);
            if (k < 12)
                put_code_sequence(t, codes[$urandom_range(0, codes.size() - 1)],
                                  codes[$urandom_range(0, codes.size() - 1)]);
            else if (k < 30)
                send_request(ACT_READ, t[2:0], 9'($urandom), 11'($urandom));
            else if (k < 45) put_char(t, NEWLINE);
            else if (k < 50) put_char(t, BACKSPACE);
            else if (k < 55) put_char(t, {1'b0, ESC_CHAR});
            else if (k < 60) put_char(t, OPEN_SQUARE);
            else put_char(t, 9'($urandom));
        end
    endtask

    initial begin
        failures = 0;
        requests_sent = 0;
        results_checked = 0;
        scrolls_seen = 0;
        quiet_phase = 1'b0;
        out_burst = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_action = 1'b0;
        i_terminal = '0;
        i_char_code = '0;
        i_cell_index = '0;
        default_attr = ATTR_RESET;
        for (int t = 0; t < TERMS; t++) begin
            for (int i = 0; i < CELLS; i++) screen_model[t][i] = '0;
            cursor_model[t] = 0;
            mode_model[t] = MODE_NORMAL;
            attr_model[t] = ATTR_RESET;
            code_model[t] = '0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_printables();
        test_colour_codes();
        set_default_attr(8'h00);
        test_escape_cases();
        set_default_attr(8'hFF);
        test_scroll();
        set_default_attr(8'($urandom));
        test_random(75);
        set_default_attr(8'h5A);
        test_random(150);

        wait_drained();
        repeat (100) @(negedge i_clk);
        $display("Checked %0d results from %0d requests, %0d predicted scrolls,",
                 results_checked, requests_sent, scrolls_seen);
        $display("covering colour codes, escape cases, reads and four default attributes.");
        if (failures == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
